>>> rtl/pcuf_pkg.sv
// Package for the patch container upload framer.
// Holds the item and job types, command constants and the chunk CRC step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcuf_pkg;

    localparam logic [31:0] CONTAINER_TAG = 32'h656d3933;
    localparam logic [15:0] OP_START      = 16'hFC27;
    localparam logic [15:0] OP_CONTINUE   = 16'hFC28;
    localparam logic [15:0] OP_RESET      = 16'hFC32;
    localparam logic [31:0] CRC_POLY      = 32'hedb88320;
    localparam logic [31:0] CRC_INIT      = 32'hffffffff;

    localparam int STORE_DEPTH = 59;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_TAG   = 2'd1;
    localparam logic [1:0] ERR_BAD_SIZE  = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [7:0] blob_byte;
        logic       blob_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] opcode;
        logic [7:0]  param_length;
        logic [15:0] sequence_res;
        logic [31:0] chunk_crc;
        logic [7:0]  payload_byte;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_RESET,
        TAIL_ERROR
    } t_tail;

    typedef struct packed {
        logic                has_hdr;
        logic                is_cont;
        logic [7:0]          plen;
        logic [15:0]         seq;
        logic [31:0]         crc;
        logic [STORE_AW-1:0] count;
        t_tail               tail;
        logic [1:0]          err;
    } t_job;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_store_wr;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HDR,
        B_PAY,
        B_TAIL
    } t_back_state;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] x;
        x = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pcuf_front.sv
// Front end of the framer: accepts blob bytes, tracks container and chunk
// state, writes the chunk store and pushes jobs to the queue. Uses pcuf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcuf_front #(
    parameter int FIRST_CHUNK = 59,
    parameter int NEXT_CHUNK  = 58
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire pcuf_pkg::t_in_item i_data,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output pcuf_pkg::t_job          o_job,
    output pcuf_pkg::t_store_wr     o_wr,
    input  wire logic               i_replay_done
);

    localparam int AW = pcuf_pkg::STORE_AW;

    logic [AW-1:0] r_fill, n_fill;
    logic [31:0]   r_pos, n_pos;
    logic [31:0]   r_len, n_len;
    logic [31:0]   r_crc, n_crc;
    logic [15:0]   r_seq, n_seq;
    logic          r_cont, n_cont;
    logic          r_halt, n_halt;
    logic          r_busy, n_busy;
    logic [31:0]   r_word, n_word;

    logic          accept;
    logic [31:0]   pos_inc;
    logic [31:0]   crc_inc;
    logic [31:0]   len_eff;
    logic [AW-1:0] fill_inc;
    logic [AW-1:0] limit;
    logic          bad_tag;
    logic          bad_size;
    logic          done;
    logic          close;
    logic [31:0]   pos_after;

    assign o_ready = !r_busy && !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_word   = {i_data.blob_byte, r_word[31:8]};
        pos_inc  = r_pos + 32'd1;
        crc_inc  = pcuf_pkg::crc_byte(r_crc, i_data.blob_byte);
        fill_inc = r_fill + AW'(1);
        limit    = r_cont ? AW'(NEXT_CHUNK) : AW'(FIRST_CHUNK);
        bad_tag  = (pos_inc == 32'd4) && (n_word != pcuf_pkg::CONTAINER_TAG);
        bad_size = (pos_inc == 32'd8) && (n_word < 32'd8);
        len_eff  = (pos_inc == 32'd8) ? n_word : r_len;
        done     = (pos_inc >= 32'd8) && (pos_inc == len_eff);
        close    = done || (fill_inc >= limit) || (fill_inc >= AW'(pcuf_pkg::STORE_DEPTH));
        pos_after = done ? 32'd0 : pos_inc;

        n_fill = r_fill;
        n_pos  = r_pos;
        n_len  = r_len;
        n_crc  = r_crc;
        n_seq  = r_seq;
        n_cont = r_cont;
        n_halt = r_halt;
        n_busy = r_busy && !i_replay_done;

        o_push        = 1'b0;
        o_job.has_hdr = 1'b0;
        o_job.is_cont = r_cont;
        o_job.plen    = r_cont ? (8'd6 + 8'(fill_inc)) : (8'd5 + 8'(fill_inc));
        o_job.seq     = r_cont ? r_seq : 16'd0;
        o_job.crc     = ~crc_inc;
        o_job.count   = fill_inc;
        o_job.tail    = pcuf_pkg::TAIL_NONE;
        o_job.err     = pcuf_pkg::ERR_NONE;

        o_wr.en   = accept && !r_halt;
        o_wr.addr = r_fill;
        o_wr.data = i_data.blob_byte;

        if (accept && !r_halt) begin
            if (bad_tag || bad_size) begin
                o_push     = 1'b1;
                o_job.tail = pcuf_pkg::TAIL_ERROR;
                o_job.err  = bad_tag ? pcuf_pkg::ERR_BAD_TAG : pcuf_pkg::ERR_BAD_SIZE;
                n_halt     = 1'b1;
            end else begin
                o_job.has_hdr = close;
                if (close) begin
                    n_fill = '0;
                    n_crc  = pcuf_pkg::CRC_INIT;
                    n_seq  = r_cont ? (r_seq + 16'd1) : 16'd1;
                    n_cont = !done;
                    n_busy = 1'b1;
                end else begin
                    n_fill = fill_inc;
                    n_crc  = crc_inc;
                end
                n_pos = pos_after;
                n_len = done ? 32'd0 : len_eff;
                if (i_data.blob_end) begin
                    n_halt = 1'b1;
                    if (pos_after != 32'd0) begin
                        o_job.tail = pcuf_pkg::TAIL_ERROR;
                        o_job.err  = pcuf_pkg::ERR_TRUNCATED;
                    end else begin
                        o_job.tail = pcuf_pkg::TAIL_RESET;
                    end
                end
                o_push = close || i_data.blob_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
            r_len  <= '0;
            r_crc  <= pcuf_pkg::CRC_INIT;
            r_seq  <= 16'd1;
            r_cont <= 1'b0;
            r_halt <= 1'b0;
            r_busy <= 1'b0;
            r_word <= '0;
        end else begin
            r_fill <= n_fill;
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_crc  <= n_crc;
            r_seq  <= n_seq;
            r_cont <= n_cont;
            r_halt <= n_halt;
            r_busy <= n_busy;
            if (accept && !r_halt) begin
                r_word <= n_word;
            end
        end
    end

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");
    a_close_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.has_hdr) |=> (r_fill == '0) && r_busy)
        else $error("chunk close did not empty the store");
    a_halt_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> !o_wr.en && !o_push)
        else $error("activity after halt");
`endif

endmodule

`default_nettype wire

>>> rtl/pcuf_queue.sv
// Short job queue between the front and back ends of the framer.
// Uses pcuf_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module pcuf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pcuf_pkg::t_job i_job,
    input  wire logic           i_pop,
    output pcuf_pkg::t_job      o_job,
    output logic                o_empty,
    output logic                o_full
);

    localparam int D  = pcuf_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    pcuf_pkg::t_job r_mem [D];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(D));
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (r_wp == PW'(D - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(D - 1)) ? '0 : r_rp + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full job queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty job queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("job queue count did not advance");
`endif

endmodule

`default_nettype wire

>>> rtl/pcuf_back.sv
// Back end of the framer: holds the chunk store, takes jobs from the queue
// and emits header, payload replay and trailing reset or error beats.
// Uses pcuf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcuf_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pcuf_pkg::t_store_wr i_wr,
    input  wire logic                i_q_empty,
    input  wire pcuf_pkg::t_job      i_job,
    output logic                     o_pop,
    output logic                     o_replay_done,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pcuf_pkg::t_out_item      o_data
);

    localparam int AW = pcuf_pkg::STORE_AW;

    logic [7:0]            r_store [pcuf_pkg::STORE_DEPTH];
    logic [7:0]            r_rd_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    pcuf_pkg::t_back_state r_state, n_state;
    pcuf_pkg::t_job        r_job;
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    pcuf_pkg::t_out_item   r_out, n_out;
    logic                  load_ok;
    logic                  last_pay;

    assign load_ok  = !r_out_valid || i_ready;
    assign last_pay = (r_idx == r_job.count - AW'(1));
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && !i_ready;
        n_out         = r_out;
        o_pop         = 1'b0;
        o_replay_done = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = r_idx + AW'(1);

        unique case (r_state)
            pcuf_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_job.has_hdr ? pcuf_pkg::B_HDR : pcuf_pkg::B_TAIL;
                end
            end
            pcuf_pkg::B_HDR: begin
                if (load_ok) begin
                    n_out_valid        = 1'b1;
                    n_out              = '0;
                    n_out.kind         = pcuf_pkg::KIND_HEADER;
                    n_out.opcode       = r_job.is_cont ? pcuf_pkg::OP_CONTINUE
                                                       : pcuf_pkg::OP_START;
                    n_out.param_length = r_job.plen;
                    n_out.sequence_res = r_job.seq;
                    n_out.chunk_crc    = r_job.crc;
                    rd_en              = 1'b1;
                    rd_addr            = '0;
                    n_idx              = '0;
                    n_state            = pcuf_pkg::B_PAY;
                end
            end
            pcuf_pkg::B_PAY: begin
                if (load_ok) begin
                    n_out_valid        = 1'b1;
                    n_out              = '0;
                    n_out.kind         = pcuf_pkg::KIND_PAYLOAD;
                    n_out.payload_byte = r_rd_data;
                    if (last_pay) begin
                        n_out.last_of_run = (r_job.tail == pcuf_pkg::TAIL_NONE);
                        o_replay_done     = 1'b1;
                        n_state = (r_job.tail == pcuf_pkg::TAIL_NONE) ? pcuf_pkg::B_IDLE
                                                                      : pcuf_pkg::B_TAIL;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            pcuf_pkg::B_TAIL: begin
                if (load_ok) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.last_of_run = 1'b1;
                    if (r_job.tail == pcuf_pkg::TAIL_ERROR) begin
                        n_out.kind       = pcuf_pkg::KIND_ERROR;
                        n_out.error_code = r_job.err;
                    end else begin
                        n_out.kind   = pcuf_pkg::KIND_HEADER;
                        n_out.opcode = pcuf_pkg::OP_RESET;
                    end
                    n_state = pcuf_pkg::B_IDLE;
                end
            end
            default: n_state = pcuf_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcuf_pkg::B_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_pop) begin
            r_job <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcuf_pkg::B_PAY) |-> (r_idx < r_job.count))
        else $error("payload index past chunk end");
    a_hdr_then_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcuf_pkg::B_HDR && load_ok) |=> (r_state == pcuf_pkg::B_PAY))
        else $error("header not followed by payload replay");
    a_error_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == pcuf_pkg::KIND_ERROR) |-> r_out.last_of_run)
        else $error("error beat not marked last");
`endif

endmodule

`default_nettype wire

>>> rtl/patch_container_upload_framer.sv
// Output: a byte that closes a chunk pushes a job into the queue; the back end pops it
// and registers its header, then one payload beat per cycle while the output is taken.
// Input: a byte that closes no chunk leaves the input ready; after a closing byte
// the next byte is taken only once the store replay of that chunk is done.
// Reset: synchronous active low; clears control state, the chunk store is not cleared.
// Top level of the framer; instantiates pcuf_front, pcuf_queue and pcuf_back.
`timescale 1ns / 1ps
`default_nettype none

module patch_container_upload_framer #(
    parameter int FIRST_CHUNK = 59,
    parameter int NEXT_CHUNK  = 58
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire pcuf_pkg::t_in_item  i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pcuf_pkg::t_out_item      o_data
);

    logic                q_full;
    logic                q_empty;
    logic                push;
    logic                pop;
    logic                replay_done;
    pcuf_pkg::t_job      push_job;
    pcuf_pkg::t_job      head_job;
    pcuf_pkg::t_store_wr store_wr;

    pcuf_front #(
        .FIRST_CHUNK (FIRST_CHUNK),
        .NEXT_CHUNK  (NEXT_CHUNK)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job),
        .o_wr          (store_wr),
        .i_replay_done (replay_done)
    );

    pcuf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pcuf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (store_wr),
        .i_q_empty     (q_empty),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_replay_done (replay_done),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data)
    );

endmodule

`default_nettype wire
